@@ src/lrast_pkg.sv @@
// Shared types and constants for the lazy range add sum/min tree block.
`timescale 1ns / 1ps
package lrast_pkg;
	localparam int LEAVES_DEF = 1024;
	localparam int CMP_W = 17;
	localparam int CFG_W = 11;
	localparam logic [63:0] EMPTY_MIN = 64'd2147483647;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_BUILD = 2'd1,
		OP_ADD   = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef struct packed {
		logic clr_wr;
		logic capture;
		logic setup;
		logic load_wr;
		logic rd;
		logic wb;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic err;
		logic empty;
		logic is_load;
		logic is_build;
		logic idx_last;
	} dp_stat_t;
endpackage

@@ src/lazy_range_add_sum_min_tree_core.sv @@
// Range add / range sum and minimum engine over up to LEAVES signed elements.
// Usage:
//  - Command channel: present operation, range_low, range_high and value with
//    start high; the transfer happens at a clock edge where busy is low.
//  - Result channel: done is high for one cycle with range_sum, range_min and
//    status; the receiver cannot stall it, so it must take it then.
//  - Config channel: cfg_valid/cfg_ready write element_count; cfg_ready is
//    always high. Write only while no command is in flight.
//  - Sequencing after acceptance: load, rejected and empty-range add or query
//    commands go from the check step to done. Range add and query walk range_low
//    to range_high, build walks element_count elements; each element takes a read
//    and a write-back step on the single-port memory, query accumulating instead.
//  - One command at a time; busy is high from acceptance until done shows.
//  - After reset, a clearing pass over all LEAVES entries zeroes the element store
//    with busy held high; element_count and the built size reset to LEAVES.
`timescale 1ns / 1ps
module lazy_range_add_sum_min_tree_core import lrast_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [9:0]         range_low,
	input  logic [9:0]         range_high,
	input  logic signed [31:0] value,
	output logic               done,
	output logic signed [63:0] range_sum,
	output logic signed [63:0] range_min,
	output logic               status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data
);
	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	lrast_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd)
	);

	lrast_dp #(.LEAVES(LEAVES)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.operation  (operation),
		.range_low  (range_low),
		.range_high (range_high),
		.value      (value),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.done       (done),
		.range_sum  (range_sum),
		.range_min  (range_min),
		.status     (status)
	);
endmodule

@@ src/lrast_dp.sv @@
// Datapath: leaf and element memories, range walk index, accumulators, result registers.
`timescale 1ns / 1ps
module lrast_dp import lrast_pkg::*; #(
	parameter int LEAVES = LEAVES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [1:0]         operation,
	input  logic [9:0]         range_low,
	input  logic [9:0]         range_high,
	input  logic signed [31:0] value,
	input  logic               cfg_valid,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               done,
	output logic signed [63:0] range_sum,
	output logic signed [63:0] range_min,
	output logic               status
);
	localparam int IW = (LEAVES > 1) ? $clog2(LEAVES) : 1;
	localparam int CW = $clog2(LEAVES + 1);

	logic [31:0] leaf_mem [LEAVES];
	logic [63:0] cur_mem [LEAVES];

	op_t         op_q;
	logic [9:0]  lo_q, hi_q;
	logic [31:0] val_q;
	logic [IW-1:0] idx_q, end_q;
	logic [CW-1:0] ec_q, bc_q, ec_nx;
	logic [63:0] sum_q, min_q, cur_rd_q, wb_data;
	logic [31:0] leaf_rd_q;
	logic        any_q, err_q, done_q, status_q;
	logic [63:0] range_sum_q, range_min_q;
	logic [CMP_W-1:0] lo_x, hi_x, ec_x, bc_x;
	logic        err_c;

	always_comb begin
		lo_x = CMP_W'(lo_q);
		hi_x = CMP_W'(hi_q);
		ec_x = CMP_W'(ec_q);
		bc_x = CMP_W'(bc_q);
		case (op_q)
			OP_LOAD:  err_c = lo_x >= ec_x;
			OP_BUILD: err_c = 1'b0;
			default:  err_c = lo_x >= ec_x || hi_x >= ec_x || lo_x >= bc_x || hi_x >= bc_x;
		endcase
		stat.clr_last = idx_q == IW'(LEAVES - 1);
		stat.err      = err_c;
		stat.empty    = hi_q < lo_q;
		stat.is_load  = op_q == OP_LOAD;
		stat.is_build = op_q == OP_BUILD;
		stat.idx_last = idx_q == end_q;
	end

	always_comb begin
		if (op_q == OP_BUILD) begin
			wb_data = {{32{leaf_rd_q[31]}}, leaf_rd_q};
		end else begin
			wb_data = cur_rd_q + {{32{val_q[31]}}, val_q};
		end
	end

	always_comb begin
		if (cfg_data == '0) begin
			ec_nx = CW'(1);
		end else if (CMP_W'(cfg_data) > CMP_W'(LEAVES)) begin
			ec_nx = CW'(LEAVES);
		end else begin
			ec_nx = CW'(cfg_data);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			leaf_mem[IW'(lo_q)] <= val_q;
		end
		if (cmd.rd) begin
			leaf_rd_q <= leaf_mem[idx_q];
			cur_rd_q  <= cur_mem[idx_q];
		end
		if (cmd.clr_wr) begin
			cur_mem[idx_q] <= '0;
		end else if (cmd.wb && op_q != OP_QUERY) begin
			cur_mem[idx_q] <= wb_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(operation);
			lo_q  <= range_low;
			hi_q  <= range_high;
			val_q <= value;
			sum_q <= '0;
			min_q <= EMPTY_MIN;
			any_q <= 1'b0;
		end
		if (cmd.setup) begin
			err_q <= err_c;
			end_q <= (op_q == OP_BUILD) ? IW'(ec_q - CW'(1)) : IW'(hi_q);
		end
		if (cmd.wb && op_q == OP_QUERY) begin
			sum_q <= sum_q + cur_rd_q;
			if (!any_q || $signed(cur_rd_q) < $signed(min_q)) begin
				min_q <= cur_rd_q;
			end
			any_q <= 1'b1;
		end
		if (cmd.emit) begin
			range_sum_q <= sum_q;
			range_min_q <= min_q;
			status_q    <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			ec_q   <= CW'(LEAVES);
			bc_q   <= CW'(LEAVES);
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cfg_valid) begin
				ec_q <= ec_nx;
			end
			if (cmd.setup) begin
				idx_q <= (op_q == OP_BUILD) ? '0 : IW'(lo_q);
				if (op_q == OP_BUILD) begin
					bc_q <= ec_q;
				end
			end else if (cmd.wb || cmd.clr_wr) begin
				idx_q <= idx_q + IW'(1);
			end
		end
	end

	assign done      = done_q;
	assign range_sum = range_sum_q;
	assign range_min = range_min_q;
	assign status    = status_q;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held two cycles");
	a_err_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q |-> range_sum_q == '0 && range_min_q == EMPTY_MIN)
		else $error("rejected item carries data");
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wb |-> idx_q <= end_q) else $error("walk ran past range end");
endmodule

@@ src/lrast_ctrl.sv @@
// Controller: sequences clear pass, range checks and the element walk.
`timescale 1ns / 1ps
module lrast_ctrl import lrast_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_RD,
		ST_WB,
		ST_DONE
	} state_t;

	state_t state_q, state_nx;
	logic   busy_q;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_CLEAR: if (stat.clr_last) state_nx = ST_IDLE;
			ST_IDLE:  if (start) state_nx = ST_CHECK;
			ST_CHECK: begin
				if (stat.is_load || stat.err || (stat.empty && !stat.is_build)) begin
					state_nx = ST_DONE;
				end else begin
					state_nx = ST_RD;
				end
			end
			ST_RD:    state_nx = ST_WB;
			ST_WB:    state_nx = stat.idx_last ? ST_DONE : ST_RD;
			ST_DONE:  state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.clr_wr  = state_q == ST_CLEAR;
		cmd.capture = state_q == ST_IDLE && start;
		cmd.setup   = state_q == ST_CHECK;
		cmd.load_wr = state_q == ST_CHECK && stat.is_load && !stat.err;
		cmd.rd      = state_q == ST_RD;
		cmd.wb      = state_q == ST_WB;
		cmd.emit    = state_q == ST_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			busy_q  <= 1'b1;
		end else begin
			state_q <= state_nx;
			busy_q  <= state_nx != ST_IDLE;
		end
	end

	assign busy = busy_q;
endmodule
